>>> hw/rtl/periodic_task_slot_scheduler_assert.svh
// Assertion macros for the periodic task slot scheduler.
// Included by the modules that assert; depends on nothing else.
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define PTSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define PTSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");
`else
`define PTSS_ASSERT_NOW(label, clk, rst, ante, cons)
`define PTSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/ptss_pkg.sv
// Shared types and constants of the periodic task slot scheduler.
// No dependencies; imported by the top level.
package ptss_pkg;

   localparam int SLOTS     = 8;
   localparam int ID_WIDTH  = 8;
   localparam int TASK_ID_W = 8;
   localparam int TIME_W    = 32;
   localparam int STEP_W    = 16;
   localparam int FUNC_W    = 2;

   // Stored id width: the low ID_WIDTH bits of the task id, never more than the port has.
   localparam int ID_W  = (ID_WIDTH < TASK_ID_W) ? ID_WIDTH : TASK_ID_W;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10);

   typedef enum logic [FUNC_W-1:0] {
      FN_TICK  = 2'd0,
      FN_ADD   = 2'd1,
      FN_DEL   = 2'd2,
      FN_CHECK = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] counter;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> hw/rtl/ptss_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ptss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/periodic_task_slot_scheduler.sv
// Top level of the periodic task slot scheduler: control sequencer around the task table.
// Depends on ptss_pkg, ptss_ram and periodic_task_slot_scheduler_assert.svh.
`include "periodic_task_slot_scheduler_assert.svh"

// The block holds up to SLOTS periodic tasks in one synchronous RAM, each entry
// carrying an id, a period and an elapsed counter. A command is taken when start is
// high and busy is low. Every command walks the live entries once through the RAM's
// read port, one entry per cycle with the data handled in the cycle after its read,
// then passes through a finishing state. An add on a full table, or any command on
// an empty table, needs no walk and goes straight to the finishing state. Results
// come out as single-cycle beats on the rsp_ ports, marked by rsp_valid; the receiver
// cannot stall them and must take every beat. A tick gives one beat per task that
// fires, in table order, or a single beat with rsp_fired low when none fires; every
// other command gives exactly one beat. rsp_last marks the final beat of a command
// and busy falls together with it. The tick step register is written through csr_
// and is always ready; it should only be written while the block is idle.
module periodic_task_slot_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   // Command channel
   input  logic                              start,
   output logic                              busy,
   input  logic [ptss_pkg::FUNC_W-1:0]       req_func,
   input  logic [ptss_pkg::TASK_ID_W-1:0]    req_task_id,
   input  logic [ptss_pkg::TIME_W-1:0]       req_period,
   // Result channel
   output logic                              rsp_valid,
   output logic                              rsp_fired,
   output logic [ptss_pkg::TASK_ID_W-1:0]    rsp_fired_id,
   output logic [ptss_pkg::TIME_W-1:0]       rsp_remaining,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last,
   // Tick step register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ptss_pkg::STEP_W-1:0]       csr_data
);

   import ptss_pkg::*;

   // IDLE waits for a command, SCAN walks the live entries, FINISH writes back or reports the
   // result of a search, or closes a tick.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] period_ff, period_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Walk: next entry to read, and the entry whose read data is now on the RAM output.
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              dv_ff, dv_in;
   logic [IDX_W-1:0]  dix_ff, dix_in;

   // Search results, captured as the walk goes by.
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  match_ff, match_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   entry_type         tail_ff, tail_in;

   // A fired task held back until we know whether another one follows it.
   logic              pend_ff, pend_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;

   // Registered result beat.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_fired_ff, rsp_fired_in;
   logic [ID_W-1:0]   rsp_fired_id_ff, rsp_fired_id_in;
   logic [TIME_W-1:0] rsp_remaining_ff, rsp_remaining_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   // RAM ports
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   entry_type         ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   entry_type         ram_rd_data;

   logic              accept;
   logic              issue;
   logic              table_full;
   logic [TIME_W:0]   tick_sum;
   logic [TIME_W-1:0] tick_next;
   logic              tick_fire;
   logic              at_tail;

   assign accept     = start && (state_ff == S_IDLE);
   assign table_full = (count_ff >= CNT_W'(SLOTS));
   assign issue      = (rd_cnt_ff < count_ff);
   assign at_tail    = (CNT_W'(dix_ff) == (count_ff - CNT_W'(1)));

   // Saturating counter advance for the entry now leaving the RAM.
   assign tick_sum  = {1'b0, ram_rd_data.counter} + (TIME_W + 1)'(step_ff);
   assign tick_next = tick_sum[TIME_W] ? {TIME_W{1'b1}} : tick_sum[TIME_W-1:0];
   assign tick_fire = (tick_next >= ram_rd_data.period);

   assign ram_rd_addr = rd_cnt_ff[IDX_W-1:0];

   ptss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in         = state_ff;
      func_in          = func_ff;
      id_in            = id_ff;
      period_in        = period_ff;
      count_in         = count_ff;
      step_in          = step_ff;
      rd_cnt_in        = rd_cnt_ff;
      dv_in            = 1'b0;
      dix_in           = dix_ff;
      found_in         = found_ff;
      match_in         = match_ff;
      rem_in           = rem_ff;
      tail_in          = tail_ff;
      pend_in          = pend_ff;
      pend_id_in       = pend_id_ff;
      rsp_valid_in     = 1'b0;
      rsp_fired_in     = 1'b0;
      rsp_fired_id_in  = '0;
      rsp_remaining_in = '0;
      rsp_status_in    = ST_OK;
      rsp_last_in      = 1'b0;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = dix_ff;
      ram_wr_data      = ram_rd_data;

      if (csr_valid) begin
         step_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in   = func_type'(req_func);
               id_in     = req_task_id[ID_W-1:0];
               period_in = req_period;
               rd_cnt_in = '0;
               found_in  = 1'b0;
               pend_in   = 1'b0;
               // Nothing to walk on an empty table, and a full table refuses any add.
               if ((count_ff == '0) ||
                   ((func_type'(req_func) == FN_ADD) && table_full)) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               dv_in     = 1'b1;
               dix_in    = rd_cnt_ff[IDX_W-1:0];
            end else begin
               state_in = S_FINISH;
            end

            if (dv_ff) begin
               if (func_ff == FN_TICK) begin
                  // Each entry is written back once its read data is on the RAM output, never clashing
                  // with the read of the entry after it.
                  ram_wr_en           = 1'b1;
                  ram_wr_data.counter = tick_fire ? '0 : tick_next;
                  if (tick_fire) begin
                     if (pend_ff) begin
                        rsp_valid_in    = 1'b1;
                        rsp_fired_in    = 1'b1;
                        rsp_fired_id_in = pend_id_ff;
                     end
                     pend_in    = 1'b1;
                     pend_id_in = ram_rd_data.id;
                  end
               end else begin
                  if (!found_ff && (ram_rd_data.id == id_ff)) begin
                     found_in = 1'b1;
                     match_in = dix_ff;
                     rem_in   = ram_rd_data.period - ram_rd_data.counter;
                  end
                  if (at_tail) begin
                     tail_in = ram_rd_data;
                  end
               end
            end
         end

         S_FINISH: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            case (func_ff)
               FN_TICK: begin
                  rsp_fired_in    = pend_ff;
                  rsp_fired_id_in = pend_ff ? pend_id_ff : '0;
                  pend_in         = 1'b0;
               end
               FN_ADD: begin
                  if (table_full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = found_ff ? match_ff : count_ff[IDX_W-1:0];
                     ram_wr_data = '{id: id_ff, period: period_ff, counter: '0};
                     if (!found_ff) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
               end
               FN_DEL: begin
                  if (!found_ff) begin
                     rsp_status_in = ST_NOT_FOUND;
                  end else begin
                     // The tail entry fills the hole; when the hole is the tail this
                     // rewrites it unchanged before it drops out of the live range.
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = match_ff;
                     ram_wr_data = tail_ff;
                     count_in    = count_ff - CNT_W'(1);
                  end
               end
               FN_CHECK: begin
                  if (!found_ff) begin
                     rsp_status_in = ST_NOT_FOUND;
                  end else begin
                     rsp_remaining_in = rem_ff;
                  end
               end
               default: begin
                  rsp_status_in = ST_OK;
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= STEP_RESET;
         dv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         dv_ff        <= dv_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff          <= func_in;
      id_ff            <= id_in;
      period_ff        <= period_in;
      rd_cnt_ff        <= rd_cnt_in;
      dix_ff           <= dix_in;
      match_ff         <= match_in;
      rem_ff           <= rem_in;
      tail_ff          <= tail_in;
      pend_id_ff       <= pend_id_in;
      rsp_fired_ff     <= rsp_fired_in;
      rsp_fired_id_ff  <= rsp_fired_id_in;
      rsp_remaining_ff <= rsp_remaining_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fired     = rsp_fired_ff;
   assign rsp_fired_id  = TASK_ID_W'(rsp_fired_id_ff);
   assign rsp_remaining = rsp_remaining_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   // The table never claims more live entries than it has slots.
   `PTSS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(SLOTS))
   // The final beat of a command coincides with the return to idle.
   `PTSS_ASSERT_NOW(a_last_idle, clock, reset, rsp_valid_ff && rsp_last_ff, state_ff == S_IDLE)
   // Beats that are not final only appear while the block is busy, and always report a fired task.
   `PTSS_ASSERT_NOW(a_mid_busy, clock, reset, rsp_valid_ff && !rsp_last_ff,
                    (state_ff != S_IDLE) && rsp_fired_ff)
   // A taken command keeps the block busy in the following cycle.
   `PTSS_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)

endmodule
